>>> design/sga_pkg.sv
// Shared types, codes and arithmetic helpers of the state vector gate block.
package sga_pkg;

	localparam int MAX_QUBITS_DEF = 10;
	localparam int NQ_W = 5;
	localparam logic [16:0] HADAMARD_K = 17'd46341;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_GATE  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		GATE_X     = 3'd0,
		GATE_Y     = 3'd1,
		GATE_Z     = 3'd2,
		GATE_H     = 3'd3,
		GATE_CNOT  = 3'd4,
		GATE_SWAP  = 3'd5,
		GATE_BAD6  = 3'd6,
		GATE_BAD7  = 3'd7
	} gate_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FEW   = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef logic [3:0] nq_cfg_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         index;
		logic signed [15:0] amp_real;
		logic signed [15:0] amp_imag;
		logic [2:0]         gate;
		logic [3:0]         qubit_a;
		logic [3:0]         qubit_b;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_real;
		logic signed [15:0] out_imag;
		logic [1:0]         status;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic latch;
		logic wr_item;
		logic rd_item;
		logic rd_pair;
		logic wr_a;
		logic wr_b;
		logic load_out;
	} sga_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [1:0] cmd;
		logic       idx_ok;
		logic       gate_run;
		logic       pairs_done;
	} sga_stat_t;

	// Negation that maps the most negative value to the most positive one.
	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v == 16'sh8000) begin
			r = 16'sh7FFF;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	// Scale a 17-bit sum by 1/sqrt(2): round to nearest with ties up, saturate.
	function automatic logic signed [15:0] hscale(input logic signed [16:0] s);
		logic signed [33:0] p;
		logic signed [33:0] q;
		logic signed [15:0] r;
		p = s * $signed(HADAMARD_K);
		q = (p + 34'sd32768) >>> 16;
		if (q > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (q < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = q[15:0];
		end
		return r;
	endfunction

endpackage

>>> design/sga_stream_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface sga_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/sga_gate_alu.sv
// Combinational gate arithmetic on one amplitude pair.
module sga_gate_alu (
	input  logic [2:0]  gate,
	input  logic        cnot_odd,
	input  logic [31:0] amp_a,
	input  logic [31:0] amp_b,
	output logic [31:0] new_a,
	output logic [31:0] new_b
);
	logic signed [15:0] a_re, a_im, b_re, b_im;
	logic signed [16:0] s_re, s_im, d_re, d_im;

	assign a_re = amp_a[31:16];
	assign a_im = amp_a[15:0];
	assign b_re = amp_b[31:16];
	assign b_im = amp_b[15:0];

	assign s_re = {a_re[15], a_re} + {b_re[15], b_re};
	assign s_im = {a_im[15], a_im} + {b_im[15], b_im};
	assign d_re = {a_re[15], a_re} - {b_re[15], b_re};
	assign d_im = {a_im[15], a_im} - {b_im[15], b_im};

	always_comb begin
		new_a = amp_a;
		new_b = amp_b;
		unique case (sga_pkg::gate_t'(gate))
			sga_pkg::GATE_X, sga_pkg::GATE_SWAP: begin
				new_a = amp_b;
				new_b = amp_a;
			end
			sga_pkg::GATE_Y: begin
				new_a = {b_im, sga_pkg::neg_sat(b_re)};
				new_b = {sga_pkg::neg_sat(a_im), a_re};
			end
			sga_pkg::GATE_Z: begin
				new_b = {sga_pkg::neg_sat(b_re), sga_pkg::neg_sat(b_im)};
			end
			sga_pkg::GATE_H: begin
				new_a = {sga_pkg::hscale(s_re), sga_pkg::hscale(s_im)};
				new_b = {sga_pkg::hscale(d_re), sga_pkg::hscale(d_im)};
			end
			sga_pkg::GATE_CNOT: begin
				if (cnot_odd) begin
					new_a = amp_b;
					new_b = amp_a;
				end
			end
			default: begin
				new_a = amp_a;
				new_b = amp_b;
			end
		endcase
	end
endmodule

>>> design/sga_datapath.sv
// Datapath: item register, pair address generator, amplitude memory, result register.
module sga_datapath #(
	parameter int MAX_QUBITS = sga_pkg::MAX_QUBITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sga_pkg::in_item_t    in_item,
	input  logic                 cfg_we,
	input  sga_pkg::nq_cfg_t     cfg_data,
	input  sga_pkg::sga_cmd_t    ctl,
	output sga_pkg::sga_stat_t   stat,
	output sga_pkg::out_item_t   out_item
);
	localparam int AW    = MAX_QUBITS;
	localparam int DEPTH = 1 << AW;

	sga_pkg::in_item_t         item_q;
	sga_pkg::nq_cfg_t          num_qubits_q;
	sga_pkg::out_item_t        out_q;
	logic [sga_pkg::NQ_W-1:0]  n_eff;
	logic                      idx_ok;
	sga_pkg::status_t          gate_st;
	sga_pkg::status_t          res_st;
	logic [AW-1:0]             pair_q;
	logic [AW-1:0]             half;
	logic [AW-1:0]             ma, mb, lo_mask, sx, pi, pj;
	logic                      qb_set;
	logic [AW-1:0]             addr_a_q, addr_b_q;
	logic [AW-1:0]             rd_addr_a, rd_addr_b, wr_addr;
	logic [31:0]               wr_data;
	logic                      wr_en, rd_en;
	logic [31:0]               rd_a_q, rd_b_q;
	logic [31:0]               new_a, new_b;
	logic [31:0]               mem [DEPTH];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_qubits_q <= 4'd10;
		end else if (cfg_we) begin
			num_qubits_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= in_item;
		end
	end

	// Effective qubit count, clamped to 1..MAX_QUBITS.
	always_comb begin
		if (num_qubits_q == '0) begin
			n_eff = sga_pkg::NQ_W'(1);
		end else if ({1'b0, num_qubits_q} > sga_pkg::NQ_W'(MAX_QUBITS)) begin
			n_eff = sga_pkg::NQ_W'(MAX_QUBITS);
		end else begin
			n_eff = {1'b0, num_qubits_q};
		end
	end

	assign idx_ok = ((item_q.index >> n_eff) == '0);

	always_comb begin
		unique case (sga_pkg::gate_t'(item_q.gate))
			sga_pkg::GATE_X, sga_pkg::GATE_Y, sga_pkg::GATE_Z, sga_pkg::GATE_H: begin
				gate_st = sga_pkg::ST_OK;
			end
			sga_pkg::GATE_CNOT: begin
				gate_st = (n_eff < sga_pkg::NQ_W'(2)) ? sga_pkg::ST_FEW : sga_pkg::ST_OK;
			end
			sga_pkg::GATE_SWAP: begin
				if (({1'b0, item_q.qubit_a} >= n_eff) || ({1'b0, item_q.qubit_b} >= n_eff)) begin
					gate_st = sga_pkg::ST_RANGE;
				end else begin
					gate_st = sga_pkg::ST_OK;
				end
			end
			default: begin
				gate_st = sga_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		unique case (sga_pkg::cmd_t'(item_q.command))
			sga_pkg::CMD_WRITE, sga_pkg::CMD_READ: begin
				res_st = idx_ok ? sga_pkg::ST_OK : sga_pkg::ST_RANGE;
			end
			sga_pkg::CMD_GATE: res_st = gate_st;
			default:           res_st = sga_pkg::ST_OK;
		endcase
	end

	assign stat.cmd        = item_q.command;
	assign stat.idx_ok     = idx_ok;
	assign stat.gate_run   = (gate_st == sga_pkg::ST_OK) &&
		!((sga_pkg::gate_t'(item_q.gate) == sga_pkg::GATE_SWAP) &&
		(item_q.qubit_a == item_q.qubit_b));
	assign stat.pairs_done = (pair_q == half);

	// Pair counter runs over half the active entries.
	assign half = AW'(1) << (n_eff - sga_pkg::NQ_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (ctl.latch) begin
			pair_q <= '0;
		end else if (ctl.rd_pair) begin
			pair_q <= pair_q + AW'(1);
		end
	end

	// Pair addresses for the pair number held in the counter.
	assign ma      = AW'(1) << item_q.qubit_a;
	assign mb      = AW'(1) << item_q.qubit_b;
	assign lo_mask = ma - AW'(1);
	assign sx      = ((pair_q >> item_q.qubit_a) << ({1'b0, item_q.qubit_a} + 5'd1)) |
		(pair_q & lo_mask);
	assign qb_set  = ((sx >> item_q.qubit_b) & AW'(1)) != '0;

	always_comb begin
		unique case (sga_pkg::gate_t'(item_q.gate))
			sga_pkg::GATE_CNOT: begin
				pi = ((pair_q >> 1) << 2) | (pair_q & AW'(1));
				pj = pi | AW'(2);
			end
			sga_pkg::GATE_SWAP: begin
				// Entries with the first qubit clear pair up with the entry that has
				// both qubits flipped when the second qubit is set, else with themselves.
				pi = sx;
				pj = qb_set ? (sx ^ ma ^ mb) : sx;
			end
			default: begin
				pi = pair_q << 1;
				pj = (pair_q << 1) | AW'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_pair) begin
			addr_a_q <= pi;
			addr_b_q <= pj;
		end
	end

	assign rd_addr_a = ctl.rd_pair ? pi : AW'(item_q.index);
	assign rd_addr_b = pj;
	assign rd_en     = ctl.rd_pair | ctl.rd_item;

	sga_gate_alu u_alu (
		.gate     (item_q.gate),
		.cnot_odd (addr_a_q[0]),
		.amp_a    (rd_a_q),
		.amp_b    (rd_b_q),
		.new_a    (new_a),
		.new_b    (new_b)
	);

	always_comb begin
		wr_en = ctl.wr_item | ctl.wr_a | ctl.wr_b;
		priority if (ctl.wr_item) begin
			wr_addr = AW'(item_q.index);
			wr_data = {item_q.amp_real, item_q.amp_imag};
		end else if (ctl.wr_a) begin
			wr_addr = addr_a_q;
			wr_data = new_a;
		end else begin
			wr_addr = addr_b_q;
			wr_data = new_b;
		end
	end

	// Amplitude memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.status <= res_st;
			if ((sga_pkg::cmd_t'(item_q.command) == sga_pkg::CMD_READ) && idx_ok) begin
				out_q.out_real <= rd_a_q[31:16];
				out_q.out_imag <= rd_a_q[15:0];
			end else begin
				out_q.out_real <= '0;
				out_q.out_imag <= '0;
			end
		end
	end

	assign out_item = out_q;
endmodule

>>> design/sga_ctrl.sv
// Controller state machine: sequences commands and owns the channel handshakes.
module sga_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sga_pkg::sga_stat_t stat,
	output sga_pkg::sga_cmd_t  ctl
);
	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_DECODE  = 5'b00010,
		S_GATE_WA = 5'b00100,
		S_GATE_WB = 5'b01000,
		S_RESP    = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESP;
				unique case (sga_pkg::cmd_t'(stat.cmd))
					sga_pkg::CMD_WRITE: ctl.wr_item = stat.idx_ok;
					sga_pkg::CMD_READ:  ctl.rd_item = stat.idx_ok;
					sga_pkg::CMD_GATE: begin
						if (stat.gate_run) begin
							ctl.rd_pair = 1'b1;
							state_d     = S_GATE_WA;
						end
					end
					default: ;
				endcase
			end
			S_GATE_WA: begin
				ctl.wr_a = 1'b1;
				state_d  = S_GATE_WB;
			end
			S_GATE_WB: begin
				ctl.wr_b = 1'b1;
				if (stat.pairs_done) begin
					state_d = S_RESP;
				end else begin
					ctl.rd_pair = 1'b1;
					state_d     = S_GATE_WA;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

>>> design/statevector_gate_apply_core.sv
// Top level of the state vector gate engine.
// The block keeps up to 2**MAX_QUBITS complex amplitudes (Q1.15 real and
// imaginary parts) and takes one command per transfer on in_ch: write one
// amplitude, read one amplitude, or apply a gate in place to the active part.
// Every command returns exactly one result transfer on out_ch, carrying the
// read data (zero for other commands) and a status code.
// The cfg_ch channel sets the number of active qubits; it is always ready and
// is meant to be written only while no command is outstanding.
// A write, a read or an unused command passes through the decode and response
// states. A gate walks the amplitude pairs of the active region and writes
// each pair back through the states S_GATE_WA and S_GATE_WB, one amplitude at
// a time, as set by the single write port of the amplitude memory. Gates that
// fail their checks, and a SWAP of a qubit with itself, skip the pair loop.
// One command is processed at a time. in_ch.ready is high only while the
// controller is idle; it rises again while the previous result still waits
// in the output register, so a stalled receiver costs nothing until the next
// result is ready, at which point the block holds until out_ch drains.
// Reset clears the controller and sets the qubit count to ten; the amplitude
// memory is not cleared and must be written before it is read.
module statevector_gate_apply_core #(
	parameter int MAX_QUBITS = sga_pkg::MAX_QUBITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sga_stream_if.sink   in_ch,
	sga_stream_if.source out_ch,
	sga_stream_if.sink   cfg_ch
);
	sga_pkg::sga_cmd_t  ctl;
	sga_pkg::sga_stat_t stat;
	sga_pkg::out_item_t out_item;

	// Configuration writes are taken in any cycle.
	assign cfg_ch.ready = 1'b1;

	sga_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	sga_datapath #(
		.MAX_QUBITS (MAX_QUBITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch.payload),
		.cfg_we   (cfg_ch.valid),
		.cfg_data (cfg_ch.payload),
		.ctl      (ctl),
		.stat     (stat),
		.out_item (out_item)
	);

	assign out_ch.payload = out_item;
endmodule

>>> design/sga_checker.sv
// Port-level checker for the state vector gate engine, bound to the top level.
module sga_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [33:0] out_payload
);
	// Only one command is in flight: an input transfer closes the input side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again right after a transfer");

	// No result can appear the cycle after an input transfer.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result raised too early");

	// The reserved status code never leaves the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_payload[1:0] != sga_pkg::ST_RSVD))
		else $error("reserved status code on output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_payload))
		else $error("result changed while stalled");
endmodule

bind statevector_gate_apply_core sga_checker u_sga_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);

>>> tb/testbench.sv
// Self-checking testbench for the state vector gate engine: command stream, replies, qubit count.
`timescale 1ns / 100ps

module testbench;
	import sga_pkg::*;

	localparam int MAX_Q = MAX_QUBITS_DEF;
	localparam int STORE_WORDS = 1 << MAX_Q;
	localparam int ROOT_HALF_Q16 = 46341;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	sga_stream_if #(.payload_t(in_item_t)) in_ch ();
	sga_stream_if #(.payload_t(out_item_t)) out_ch ();
	sga_stream_if #(.payload_t(nq_cfg_t)) cfg_ch ();

	statevector_gate_apply_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// Two shadow copies of the amplitude store. Copy 0 runs ahead with the
	// generator so that it knows which entries hold written data; copy 1 is
	// advanced on every accepted transfer and produces the expected replies.
	// A "known" flag follows each word through the gates, so that an entry
	// mixed with never-written data is never read back.
	logic [31:0] shadow_amp [2][STORE_WORDS];
	bit shadow_known [2][STORE_WORDS];
	nq_cfg_t shadow_nq [2];

	in_item_t queued_commands[$];
	out_item_t pending_replies[$];

	bit in_took;
	bit out_took;
	int send_wait;
	int sent_count;
	int rx_wait;
	int rx_count;
	int hold_left;
	int hold_requests;
	int holds_served;
	int mismatch_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Active qubit count after clamping the register to 1..MAX_Q.
	function automatic int active_qubits(input nq_cfg_t v);
		int n;
		n = v;
		if (n < 1) n = 1;
		if (n > MAX_Q) n = MAX_Q;
		return n;
	endfunction

	// Negation that cannot overflow: the most negative value maps to the most positive one.
	function automatic logic signed [15:0] flip_sat(input logic signed [15:0] v);
		if (v == -16'sd32768) return 16'sh7FFF;
		return -v;
	endfunction

	// Multiply an exact 17-bit sum by 1/sqrt(2) in Q16, round half up, and saturate.
	function automatic logic signed [15:0] half_root_scale(input int sum);
		longint prod;
		longint q;
		prod = longint'(sum) * ROOT_HALF_Q16;
		q = (prod + 32768) >>> 16;
		if (q > 32767) return 16'sh7FFF;
		if (q < -32768) return 16'sh8000;
		return q[15:0];
	endfunction

	function automatic void exchange(input int s, input int i, input int j);
		logic [31:0] w;
		bit k;
		w = shadow_amp[s][i];
		shadow_amp[s][i] = shadow_amp[s][j];
		shadow_amp[s][j] = w;
		k = shadow_known[s][i];
		shadow_known[s][i] = shadow_known[s][j];
		shadow_known[s][j] = k;
	endfunction

	function automatic status_t gate_on_shadow(input int s, input int n, input gate_t g,
			input int qa, input int qb);
		int size;
		int i;
		int ma;
		int mb;
		logic signed [15:0] ar, ai, br, bi;
		bit both;
		size = 1 << n;
		case (g)
			GATE_X: begin
				for (i = 0; i < size; i += 2) exchange(s, i, i + 1);
			end
			GATE_Y: begin
				// Y maps the pair (a, b) to (-i*b, i*a).
				for (i = 0; i < size; i += 2) begin
					{ar, ai} = shadow_amp[s][i];
					{br, bi} = shadow_amp[s][i + 1];
					shadow_amp[s][i] = {bi, flip_sat(br)};
					shadow_amp[s][i + 1] = {flip_sat(ai), ar};
					both = shadow_known[s][i];
					shadow_known[s][i] = shadow_known[s][i + 1];
					shadow_known[s][i + 1] = both;
				end
			end
			GATE_Z: begin
				for (i = 1; i < size; i += 2) begin
					{ar, ai} = shadow_amp[s][i];
					shadow_amp[s][i] = {flip_sat(ar), flip_sat(ai)};
				end
			end
			GATE_H: begin
				for (i = 0; i < size; i += 2) begin
					{ar, ai} = shadow_amp[s][i];
					{br, bi} = shadow_amp[s][i + 1];
					shadow_amp[s][i] = {half_root_scale(int'(ar) + int'(br)),
						half_root_scale(int'(ai) + int'(bi))};
					shadow_amp[s][i + 1] = {half_root_scale(int'(ar) - int'(br)),
						half_root_scale(int'(ai) - int'(bi))};
					both = shadow_known[s][i] && shadow_known[s][i + 1];
					shadow_known[s][i] = both;
					shadow_known[s][i + 1] = both;
				end
			end
			GATE_CNOT: begin
				if (n < 2) return ST_FEW;
				for (i = 1; i < size; i += 4) exchange(s, i, i + 2);
			end
			GATE_SWAP: begin
				if (qa >= n || qb >= n) return ST_RANGE;
				if (qa == qb) return ST_OK;
				ma = 1 << qa;
				mb = 1 << qb;
				for (i = 0; i < size; i++) begin
					if ((i & ma) != 0 && (i & mb) == 0) exchange(s, i, i ^ ma ^ mb);
				end
			end
			default: return ST_RANGE;
		endcase
		return ST_OK;
	endfunction

	// Apply one command to shadow copy s and return the reply it must produce.
	function automatic out_item_t shadow_execute(input int s, input in_item_t it);
		out_item_t r;
		int size;
		int n;
		n = active_qubits(shadow_nq[s]);
		size = 1 << n;
		r = '0;
		r.status = ST_OK;
		case (cmd_t'(it.command))
			CMD_WRITE: begin
				if (it.index >= size) begin
					r.status = ST_RANGE;
				end else begin
					shadow_amp[s][it.index] = {it.amp_real, it.amp_imag};
					shadow_known[s][it.index] = 1'b1;
				end
			end
			CMD_GATE: begin
				r.status = gate_on_shadow(s, n, gate_t'(it.gate), it.qubit_a, it.qubit_b);
			end
			CMD_READ: begin
				if (it.index >= size) r.status = ST_RANGE;
				else {r.out_real, r.out_imag} = shadow_amp[s][it.index];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic in_item_t command_item(input cmd_t c, input int idx, input int re,
			input int im, input gate_t g, input int qa, input int qb);
		in_item_t it;
		it.command = c;
		it.index = 10'(idx);
		it.amp_real = 16'(re);
		it.amp_imag = 16'(im);
		it.gate = g;
		it.qubit_a = 4'(qa);
		it.qubit_b = 4'(qb);
		return it;
	endfunction

	function automatic logic [15:0] pick_amp_part();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// A random but mostly well-formed command for n active qubits. In-range reads
	// only target entries that copy 0 knows to be written; gates stay rare when
	// the vector is large because each one walks the whole active region.
	function automatic in_item_t random_command(input int n);
		in_item_t it;
		int size;
		int pick;
		int gate_pct;
		int tries;
		int slot;
		bit found;
		size = 1 << n;
		gate_pct = (n >= 8) ? 8 : 30;
		it = command_item(CMD_WRITE, $urandom_range(0, STORE_WORDS - 1), 0, 0, GATE_X,
			$urandom_range(0, 15), $urandom_range(0, 15));
		it.amp_real = pick_amp_part();
		it.amp_imag = pick_amp_part();
		it.gate = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			it.command = CMD_NONE;
		end else if (pick < 5 + gate_pct) begin
			it.command = CMD_GATE;
			if ($urandom_range(0, 9) == 0) it.gate = 3'($urandom_range(GATE_BAD6, GATE_BAD7));
			else it.gate = 3'($urandom_range(GATE_X, GATE_SWAP));
			if ($urandom_range(0, 4) != 0) begin
				it.qubit_a = 4'($urandom_range(0, n - 1));
				it.qubit_b = 4'($urandom_range(0, n - 1));
			end
		end else if (pick < 5 + gate_pct + (95 - gate_pct) / 2) begin
			it.command = CMD_WRITE;
			if ($urandom_range(0, 9) != 0) it.index = 10'($urandom_range(0, size - 1));
		end else begin
			it.command = CMD_READ;
			if (n < MAX_Q && $urandom_range(0, 9) == 0) begin
				it.index = 10'($urandom_range(size, STORE_WORDS - 1));
			end else begin
				found = 1'b0;
				for (tries = 0; tries < 24 && !found; tries++) begin
					slot = $urandom_range(0, size - 1);
					if (shadow_known[0][slot]) begin
						it.index = 10'(slot);
						found = 1'b1;
					end
				end
				// Nothing readable was found, so write instead.
				if (!found) begin
					it.command = CMD_WRITE;
					it.index = 10'($urandom_range(0, size - 1));
				end
			end
		end
		return it;
	endfunction

	function automatic void queue_command(input in_item_t it);
		out_item_t unused;
		unused = shadow_execute(0, it);
		queued_commands.push_back(it);
	endfunction

	// Small vectors are first written in full, so that every gate keeps all of
	// the active region readable; then the random commands follow.
	task automatic queue_random(input int count);
		int n;
		int i;
		n = active_qubits(shadow_nq[0]);
		if (n <= 6) begin
			for (i = 0; i < (1 << n); i++) begin
				if (!shadow_known[0][i])
					queue_command(command_item(CMD_WRITE, i, $urandom, $urandom, GATE_X, 0, 0));
			end
		end
		for (i = 0; i < count; i++) queue_command(random_command(n));
	endtask

	// Block until every queued command has been transferred and answered.
	task automatic wait_idle();
		@(posedge clk);
		while (queued_commands.size() != 0 || in_ch.valid || pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Write the qubit count through the configuration channel; the block is idle here.
	task automatic write_qubit_count(input nq_cfg_t v);
		shadow_nq[0] = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		shadow_nq[1] = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic start_phase(input nq_cfg_t v);
		wait_idle();
		write_qubit_count(v);
	endtask

	// Command driver: each command is followed by a random gap, except in
	// back-to-back stretches where the next one is offered at once.
	always @(negedge clk) begin : command_driver
		int gap;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			send_wait <= 0;
			sent_count <= 0;
		end else if (in_ch.valid && !in_took) begin
			// The offered command has not been taken yet, so keep it stable.
		end else if (send_wait != 0) begin
			in_ch.valid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (queued_commands.size() != 0) begin
			gap = (sent_count % 64 < 16) ? 0 : $urandom_range(0, 13);
			in_ch.valid <= 1'b1;
			in_ch.payload <= queued_commands.pop_front();
			send_wait <= gap;
			sent_count <= sent_count + 1;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Reply side: a random hold-off after each reply outside back-to-back stretches,
	// plus long stalls on request, counted here, while the driver keeps offering commands.
	always @(negedge clk) begin : reply_sink
		int gap;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_wait <= 0;
			rx_count <= 0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			out_ch.ready <= 1'b0;
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD_CYCLES;
		end else if (out_took) begin
			gap = (rx_count % 48 < 12) ? 0 : $urandom_range(0, 13);
			out_ch.ready <= (gap == 0);
			rx_wait <= gap;
			rx_count <= rx_count + 1;
		end else if (rx_wait != 0) begin
			out_ch.ready <= (rx_wait == 1);
			rx_wait <= rx_wait - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Monitor: both channels are sampled at the rising edge. A reply is
	// checked before a command of the same edge is predicted, so a reply can
	// never be matched against the command that was just accepted.
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			in_took <= 1'b0;
			out_took <= 1'b0;
		end else begin
			in_took <= in_ch.valid && in_ch.ready;
			out_took <= out_ch.valid && out_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				if (pending_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("reply transfer with no command outstanding: re %0d im %0d status %0d",
							got.out_real, got.out_imag, got.status);
				end else begin
					want = pending_replies.pop_front();
					if (got.out_real !== want.out_real || got.out_imag !== want.out_imag ||
							got.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("reply mismatch: expected re %0d im %0d status %0d, got re %0d im %0d status %0d",
								want.out_real, want.out_imag, want.status,
								got.out_real, got.out_imag, got.status);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				pending_replies.push_back(shadow_execute(1, in_ch.payload));
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[statevector_gate_apply_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		int i;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		mismatch_count = 0;
		hold_requests = 0;
		for (i = 0; i < STORE_WORDS; i++) begin
			shadow_amp[0][i] = '0;
			shadow_amp[1][i] = '0;
			shadow_known[0][i] = 1'b0;
			shadow_known[1][i] = 1'b0;
		end
		shadow_nq[0] = nq_cfg_t'(MAX_Q);
		shadow_nq[1] = nq_cfg_t'(MAX_Q);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset value of ten qubits is used before any register write.
		queue_random(30);

		// Two qubits: full-scale values, saturating negation and Hadamard,
		// every gate and command code, and the out-of-range cases.
		start_phase(nq_cfg_t'(2));
		queue_command(command_item(CMD_WRITE, 0, 32767, -32768, GATE_X, 0, 0));
		queue_command(command_item(CMD_WRITE, 1, -32768, 32767, GATE_X, 0, 0));
		queue_command(command_item(CMD_WRITE, 2, 32767, 32767, GATE_X, 0, 0));
		queue_command(command_item(CMD_WRITE, 3, -32768, -32768, GATE_X, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_Z, 0, 0));
		queue_command(command_item(CMD_READ, 1, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_READ, 3, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_H, 0, 0));
		queue_command(command_item(CMD_READ, 0, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_READ, 1, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_Y, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_CNOT, 0, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_SWAP, 0, 1));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_SWAP, 1, 1));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_SWAP, 2, 0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_SWAP, 15, 15));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_BAD6, 0, 1));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_BAD7, 1, 0));
		queue_command(command_item(CMD_NONE, 1023, -1, -1, GATE_BAD7, 15, 15));
		queue_command(command_item(CMD_WRITE, 1023, -1, -1, GATE_X, 0, 0));
		queue_command(command_item(CMD_READ, 4, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_READ, 2, 0, 0, GATE_X, 0, 0));
		queue_command(command_item(CMD_READ, 3, 0, 0, GATE_X, 0, 0));
		queue_random(60);

		// A register value of zero acts as one qubit, where CNOT is refused.
		start_phase(nq_cfg_t'(0));
		queue_command(command_item(CMD_GATE, 0, 0, 0, GATE_CNOT, 0, 1));
		queue_command(command_item(CMD_READ, 1, 0, 0, GATE_X, 0, 0));
		queue_random(40);

		start_phase(nq_cfg_t'(1));
		queue_random(40);

		// Long reply stall while commands keep coming, so the block backs up.
		start_phase(nq_cfg_t'(3));
		hold_requests++;
		queue_random(70);

		// Values above the maximum act as the maximum.
		start_phase(nq_cfg_t'(15));
		queue_random(30);

		// The sender pauses mid-phase until every reply is back.
		start_phase(nq_cfg_t'(4));
		queue_random(30);
		wait_idle();
		queue_random(30);

		start_phase(nq_cfg_t'(5));
		queue_random(60);
		start_phase(nq_cfg_t'(11));
		queue_random(20);
		start_phase(nq_cfg_t'(6));
		queue_random(50);
		start_phase(nq_cfg_t'(7));
		queue_random(40);
		start_phase(nq_cfg_t'(9));
		queue_random(25);
		start_phase(nq_cfg_t'(10));
		queue_random(25);
		start_phase(nq_cfg_t'(8));
		queue_random(25);

		// Drain, then give a stray reply a chance to show up.
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_replies.size() == 0) begin
			$display("[statevector_gate_apply_core] OK");
		end else begin
			$display("[statevector_gate_apply_core] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/sga_pkg.sv
design/sga_stream_if.sv
design/sga_gate_alu.sv
design/sga_datapath.sv
design/sga_ctrl.sv
design/statevector_gate_apply_core.sv
design/sga_checker.sv
tb/testbench.sv
